// ===== hdl/two_axis_step_pulse_generator_top_macros.svh =====
// Assertion macros for the step pulse generator checker.
`ifndef TWO_AXIS_STEP_PULSE_GENERATOR_TOP_MACROS_SVH
`define TWO_AXIS_STEP_PULSE_GENERATOR_TOP_MACROS_SVH

// Clocked assertion, off while reset is asserted.
`define TSPG_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TSPG_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tspg_pkg.sv =====
// Shared constants and types for the two-axis step pulse generator.
package tspg_pkg;

  localparam int POS_BITS_DEF   = 24;
  localparam int COUNT_BITS_DEF = 16;

  localparam int PERIOD_W   = 16;
  localparam int OUT_POS_W  = 24;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 64;

  // out_tdata field positions
  localparam int OUT_X_STEP  = 0;
  localparam int OUT_X_DIR   = 1;
  localparam int OUT_Y_STEP  = 2;
  localparam int OUT_Y_DIR   = 3;
  localparam int OUT_X_POS   = 4;
  localparam int OUT_Y_POS   = OUT_X_POS + OUT_POS_W;
  localparam int OUT_X_RUN   = OUT_Y_POS + OUT_POS_W;
  localparam int OUT_Y_RUN   = OUT_X_RUN + 1;
  localparam int OUT_STOPS   = OUT_Y_RUN + 1;
  localparam int OUT_USED_W  = OUT_STOPS + 4;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_X_PERIOD = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_X_LEFT   = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_Y_PERIOD = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_Y_TOWARD = cfg_idx_t'(3);

  // Register write strobes from the config decoder
  typedef struct packed {
    logic x_period;
    logic x_dir;
    logic y_period;
    logic y_dir;
  } cfg_we_t;

  // Per-axis write strobes
  typedef struct packed {
    logic period;
    logic dir;
  } axis_we_t;

  // Per-axis pin levels and running flag after a tick
  typedef struct packed {
    logic step;
    logic dir;
    logic running;
  } axis_stat_t;

endpackage

// ===== hdl/tspg_axis.sv =====
// One axis: period/direction registers, halt flag, tick counter and position.
module tspg_axis #(
  parameter int COUNT_BITS = tspg_pkg::COUNT_BITS_DEF,
  parameter int POS_BITS   = tspg_pkg::POS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tspg_pkg::axis_we_t            we,
  input  logic [tspg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          tick,
  input  logic                          low_hit,   // stop on decrementing side
  input  logic                          high_hit,  // stop on incrementing side
  output tspg_pkg::axis_stat_t          stat_nxt,
  output logic [POS_BITS-1:0]           pos_nxt
);
  import tspg_pkg::*;

  localparam int CMP_W = (COUNT_BITS > PERIOD_W) ? COUNT_BITS : PERIOD_W;

  logic [PERIOD_W-1:0]   period_r;
  logic                  toward_r;
  logic [COUNT_BITS-1:0] count_r, count_nxt;
  logic [POS_BITS-1:0]   pos_r;
  logic                  halted_r, halted_nxt;
  logic                  step_r, step_nxt;
  logic                  dir_r, dir_nxt;
  logic                  run_chk;
  logic                  at_period;

  assign at_period = CMP_W'(count_r) >= CMP_W'(period_r);

  always_comb begin
    count_nxt  = count_r;
    pos_nxt    = pos_r;
    halted_nxt = halted_r;
    step_nxt   = step_r;
    dir_nxt    = dir_r;
    run_chk    = 1'b0;
    if (we.period || we.dir) begin
      halted_nxt = 1'b0;
    end
    if (tick) begin
      halted_nxt = halted_r | (low_hit & toward_r) | (high_hit & ~toward_r);
      run_chk    = (period_r != '0) && !halted_nxt;
      if (run_chk) begin
        if (count_r == '0) begin
          step_nxt  = 1'b0;
          count_nxt = count_r + COUNT_BITS'(1);
        end else if (at_period) begin
          dir_nxt   = toward_r;
          pos_nxt   = toward_r ? pos_r - POS_BITS'(1) : pos_r + POS_BITS'(1);
          step_nxt  = 1'b1;
          count_nxt = '0;
        end else begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end
    end
  end

  assign stat_nxt.step    = step_nxt;
  assign stat_nxt.dir     = dir_nxt;
  assign stat_nxt.running = run_chk;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= '0;
      toward_r <= 1'b0;
      count_r  <= '0;
      pos_r    <= '0;
      halted_r <= 1'b0;
      step_r   <= 1'b0;
      dir_r    <= 1'b0;
    end else begin
      if (we.period) begin
        period_r <= cfg_data[PERIOD_W-1:0];
      end
      if (we.dir) begin
        toward_r <= cfg_data[0];
      end
      count_r  <= count_nxt;
      pos_r    <= pos_nxt;
      halted_r <= halted_nxt;
      step_r   <= step_nxt;
      dir_r    <= dir_nxt;
    end
  end

endmodule

// ===== hdl/two_axis_step_pulse_generator_top.sv =====
// Two-axis step/direction pulse generator: one stream transaction in is one tick;
// each tick yields one status transaction. An accepted tick updates both axes in
// the same cycle and its result sits in a single output register, so a new tick
// is taken every clock while out_tready is high; the output register alone sets
// that rate. in_tready falls only while a result waits unaccepted. cfg writes are
// always ready and should be issued while idle.
module two_axis_step_pulse_generator_top #(
  parameter int POS_BITS   = tspg_pkg::POS_BITS_DEF,
  parameter int COUNT_BITS = tspg_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // in_tdata: [0] left_stop, [1] right_stop, [2] far_stop, [3] close_stop
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [tspg_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: [0] x_step_pin, [1] x_dir_pin, [2] y_step_pin, [3] y_dir_pin,
  // [27:4] x_pos, [51:28] y_pos, [52] x_running, [53] y_running,
  // [57:54] stop_status, upper bits zero
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [tspg_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tspg_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tspg_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tspg_pkg::*;

  logic                   tick;
  cfg_we_t                cfg_we;
  axis_we_t               x_we, y_we;
  axis_stat_t             x_stat, y_stat;
  logic [POS_BITS-1:0]    x_pos_nxt, y_pos_nxt;
  logic [OUT_POS_W-1:0]   x_pos_out, y_pos_out;
  logic                   out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign tick      = in_tvalid && in_tready;

  always_comb begin
    cfg_we = '0;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_X_PERIOD: cfg_we.x_period = 1'b1;
        CFG_X_LEFT:   cfg_we.x_dir    = 1'b1;
        CFG_Y_PERIOD: cfg_we.y_period = 1'b1;
        CFG_Y_TOWARD: cfg_we.y_dir    = 1'b1;
        default:      cfg_we = '0;
      endcase
    end
  end

  assign x_we = '{period: cfg_we.x_period, dir: cfg_we.x_dir};
  assign y_we = '{period: cfg_we.y_period, dir: cfg_we.y_dir};

  // x: left stop is on the decrementing side
  tspg_axis #(.COUNT_BITS(COUNT_BITS), .POS_BITS(POS_BITS)) u_x_axis (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (x_we),
    .cfg_data (cfg_data),
    .tick     (tick),
    .low_hit  (in_tdata[0]),
    .high_hit (in_tdata[1]),
    .stat_nxt (x_stat),
    .pos_nxt  (x_pos_nxt)
  );

  // y: close stop is on the decrementing (toward) side
  tspg_axis #(.COUNT_BITS(COUNT_BITS), .POS_BITS(POS_BITS)) u_y_axis (
    .clk      (clk),
    .rst_n    (rst_n),
    .we       (y_we),
    .cfg_data (cfg_data),
    .tick     (tick),
    .low_hit  (in_tdata[3]),
    .high_hit (in_tdata[2]),
    .stat_nxt (y_stat),
    .pos_nxt  (y_pos_nxt)
  );

  // Position to the fixed output width: sign-extend or keep the low bits
  generate
    if (POS_BITS >= OUT_POS_W) begin : g_pos_trunc
      assign x_pos_out = x_pos_nxt[OUT_POS_W-1:0];
      assign y_pos_out = y_pos_nxt[OUT_POS_W-1:0];
    end else begin : g_pos_sext
      assign x_pos_out = {{(OUT_POS_W-POS_BITS){x_pos_nxt[POS_BITS-1]}}, x_pos_nxt};
      assign y_pos_out = {{(OUT_POS_W-POS_BITS){y_pos_nxt[POS_BITS-1]}}, y_pos_nxt};
    end
  endgenerate

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (tick) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {(OUT_TDATA_W - OUT_USED_W)'(0),
                       in_tdata[3:0],
                       y_stat.running, x_stat.running,
                       y_pos_out, x_pos_out,
                       y_stat.dir, y_stat.step,
                       x_stat.dir, x_stat.step};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== hdl/tspg_checker.sv =====
// Port-level checker for the step pulse generator, bound to the top level.
`include "two_axis_step_pulse_generator_top_macros.svh"

module tspg_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [tspg_pkg::IN_TDATA_W-1:0]  in_tdata,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [tspg_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import tspg_pkg::*;

  // stalled result stays valid
  `TSPG_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "out_tvalid dropped while stalled")

  // reset empties the output register
  `TSPG_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "result valid after reset")

  // an empty output register never blocks the input
  `TSPG_ASSERT(a_in_ready, !out_tvalid |-> in_tready, "input blocked with no pending result")

  // every accepted tick shows up next cycle with its stop levels echoed
  `TSPG_ASSERT(a_tick_result, in_tvalid && in_tready |=> out_tvalid && (out_tdata[OUT_STOPS+3:OUT_STOPS] == $past(in_tdata[3:0])), "tick result missing or stop status wrong")

endmodule

bind two_axis_step_pulse_generator_top tspg_checker u_tspg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
